[rtl/lrufp_pkg.sv]
// Shared package of the block address to fingerprint map.
// Holds field widths, default parameters, command codes and the control structs.
// Depends on nothing.
package lrufp_pkg;

    localparam int ENTRIES_DEF  = 256;
    localparam int FP_BYTES_DEF = 20;

    localparam int KEY_W    = 48;
    localparam int FP_MAX_W = 160;
    localparam int CAP_W    = 9;
    localparam int CMD_W    = 2;
    localparam int IN_W     = 208;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [CMD_W-1:0] CMD_LOOKUP   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PROMOTE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic ld;
        logic rd_scan;
        logic decide;
        logic fp_rd;
        logic rd_rew;
        logic fin;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic addr_last;
        logic act;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/lrufp_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module lrufp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lrufp_ctrl.sv]
// Sequencer of the map: clearing pass, scan, decision, fingerprint access,
// rank rewrite pass and result hand-off. Depends on lrufp_pkg.
module lrufp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  lrufp_pkg::dp_status_t  st,
    output lrufp_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_SCAN   = 10'b0000000100,
        ST_SDRAIN = 10'b0000001000,
        ST_DECIDE = 10'b0000010000,
        ST_FPRD   = 10'b0000100000,
        ST_FPWAIT = 10'b0001000000,
        ST_REW    = 10'b0010000000,
        ST_RDRAIN = 10'b0100000000,
        ST_FIN    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (st.addr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.ld     = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.rd_scan = 1'b1;
                if (st.addr_last) state_next = ST_SDRAIN;
            end
            ST_SDRAIN: state_next = ST_DECIDE;
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_FPRD;
            end
            ST_FPRD: begin
                cmd.fp_rd  = 1'b1;
                state_next = ST_FPWAIT;
            end
            ST_FPWAIT: state_next = st.act ? ST_REW : ST_FIN;
            ST_REW: begin
                cmd.rd_rew = 1'b1;
                if (st.addr_last) state_next = ST_RDRAIN;
            end
            ST_RDRAIN: state_next = ST_FIN;
            ST_FIN: begin
                if (st.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

endmodule

[rtl/lrufp_datapath.sv]
// Datapath of the map: entry and fingerprint memories, scan registers,
// decision registers, occupancy, capacity and the result register.
// Depends on lrufp_pkg and lrufp_ram.
module lrufp_datapath #(
    parameter int ENTRIES  = lrufp_pkg::ENTRIES_DEF,
    parameter int FP_BYTES = lrufp_pkg::FP_BYTES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lrufp_pkg::ctrl_cmd_t               cmd,
    output lrufp_pkg::dp_status_t              st,
    input  logic [lrufp_pkg::CMD_W-1:0]        in_cmd,
    input  logic [lrufp_pkg::IN_W-1:0]         in_data,
    input  logic                               cfg_we,
    input  logic [lrufp_pkg::CAP_W-1:0]        cfg_wdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lrufp_pkg::FP_MAX_W-1:0]     m_tdata,
    output logic [1:0]                         m_tuser
);

    localparam int AW    = $clog2(ENTRIES);
    localparam int RW    = $clog2(ENTRIES);
    localparam int KW    = lrufp_pkg::KEY_W;
    localparam int MW    = 1 + KW + RW;
    localparam int FP_W  = FP_BYTES * 8;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lrufp_pkg::CAP_W) ? CNT_W : lrufp_pkg::CAP_W;

    logic [AW-1:0]   addr_reg, raddr_reg;
    logic            rv_scan_reg, rv_rew_reg, rv_fp_reg;
    logic [lrufp_pkg::CMD_W-1:0] cmd_reg;
    logic [KW-1:0]   key_reg;
    logic [FP_W-1:0] fp_in_reg, old_fp_reg;
    logic            mt_found_reg, fr_found_reg, ol_found_reg;
    logic [AW-1:0]   mt_idx_reg, fr_idx_reg, ol_idx_reg, tgt_reg;
    logic [RW-1:0]   mt_rank_reg, ol_rank_reg, thr_reg;
    logic            all_reg, ins_reg, act_reg, fpw_reg, take_reg, hit_reg, ev_reg, inc_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [lrufp_pkg::CAP_W-1:0] cap_reg;
    logic            m_tvalid_reg, out_hit_reg, out_ev_reg;
    logic [lrufp_pkg::FP_MAX_W-1:0] out_fp_reg, out_fp_next;

    logic [MW-1:0]   meta_rd, meta_wd;
    logic            meta_we;
    logic [FP_W-1:0] fp_rd;
    logic            rd_v;
    logic [KW-1:0]   rd_key;
    logic [RW-1:0]   rd_rank;
    logic [CMP_W-1:0] eff_cap, occ_w;
    logic            full;
    logic [lrufp_pkg::FP_MAX_W-1:0] fp_all_in;

    assign rd_v    = meta_rd[MW-1];
    assign rd_key  = meta_rd[RW +: KW];
    assign rd_rank = meta_rd[RW-1:0];
    assign fp_all_in = in_data[lrufp_pkg::IN_W-1:KW];

    // Address counter shared by the clearing, scan and rewrite passes.
    assign st.addr_last = (addr_reg == AW'(ENTRIES - 1));
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg    <= '0;
            rv_scan_reg <= 1'b0;
            rv_rew_reg  <= 1'b0;
            rv_fp_reg   <= 1'b0;
        end else begin
            if (cmd.clr_wr || cmd.rd_scan || cmd.rd_rew) begin
                addr_reg <= st.addr_last ? '0 : addr_reg + AW'(1);
            end
            rv_scan_reg <= cmd.rd_scan;
            rv_rew_reg  <= cmd.rd_rew;
            rv_fp_reg   <= cmd.fp_rd;
        end
        raddr_reg <= addr_reg;
    end

    // Rewrite or clearing of one entry: the target takes rank zero, younger ones age (every valid one on an insert).
    always_comb begin
        meta_we = cmd.clr_wr || rv_rew_reg;
        meta_wd = meta_rd;
        if (cmd.clr_wr) begin
            meta_wd = '0;
        end else if (raddr_reg == tgt_reg) begin
            meta_wd = {1'b1, ins_reg ? key_reg : rd_key, {RW{1'b0}}};
        end else if (rd_v && (all_reg || rd_rank < thr_reg)) begin
            meta_wd = {1'b1, rd_key, rd_rank + RW'(1)};
        end
    end

    lrufp_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (cmd.clr_wr ? addr_reg : raddr_reg),
        .wdata (meta_wd),
        .re    (cmd.rd_scan || cmd.rd_rew),
        .raddr (addr_reg),
        .rdata (meta_rd)
    );

    lrufp_ram #(.WIDTH(FP_W), .DEPTH(ENTRIES)) u_fp_ram (
        .aclk  (aclk),
        .we    (cmd.fin && fpw_reg),
        .waddr (tgt_reg),
        .wdata (fp_in_reg),
        .re    (cmd.fp_rd),
        .raddr (tgt_reg),
        .rdata (fp_rd)
    );

    // Effective capacity, clamped to one and to the table depth.
    always_comb begin
        eff_cap = CMP_W'(cap_reg);
        if (cap_reg == '0) eff_cap = CMP_W'(1);
        else if (eff_cap > CMP_W'(ENTRIES)) eff_cap = CMP_W'(ENTRIES);
        occ_w = CMP_W'(occ_reg);
        full  = (occ_w >= eff_cap) && (occ_reg != '0);
    end

    // Item capture, scan results and the decision.
    always_ff @(posedge aclk) begin
        if (cmd.ld) begin
            cmd_reg      <= in_cmd;
            key_reg      <= in_data[KW-1:0];
            fp_in_reg    <= fp_all_in[FP_W-1:0];
            mt_found_reg <= 1'b0;
            fr_found_reg <= 1'b0;
            ol_found_reg <= 1'b0;
        end
        if (rv_scan_reg) begin
            if (rd_v && rd_key == key_reg) begin
                mt_found_reg <= 1'b1;
                mt_idx_reg   <= raddr_reg;
                mt_rank_reg  <= rd_rank;
            end
            if (!rd_v && !fr_found_reg) begin
                fr_found_reg <= 1'b1;
                fr_idx_reg   <= raddr_reg;
            end
            if (rd_v && (!ol_found_reg || rd_rank > ol_rank_reg)) begin
                ol_found_reg <= 1'b1;
                ol_idx_reg   <= raddr_reg;
                ol_rank_reg  <= rd_rank;
            end
        end
        if (cmd.decide) begin
            tgt_reg  <= mt_idx_reg;
            thr_reg  <= mt_rank_reg;
            all_reg  <= 1'b0;
            ins_reg  <= 1'b0;
            act_reg  <= 1'b0;
            fpw_reg  <= 1'b0;
            take_reg <= 1'b0;
            hit_reg  <= 1'b0;
            ev_reg   <= 1'b0;
            inc_reg  <= 1'b0;
            case (cmd_reg)
                lrufp_pkg::CMD_LOOKUP: begin
                    hit_reg  <= mt_found_reg;
                    take_reg <= mt_found_reg;
                end
                lrufp_pkg::CMD_PROMOTE: begin
                    act_reg <= mt_found_reg;
                end
                lrufp_pkg::CMD_UPDATE: begin
                    if (mt_found_reg) begin
                        act_reg  <= 1'b1;
                        fpw_reg  <= 1'b1;
                        take_reg <= 1'b1;
                        ev_reg   <= 1'b1;
                    end else if (full) begin
                        tgt_reg  <= ol_idx_reg;
                        all_reg  <= 1'b1;
                        ins_reg  <= 1'b1;
                        act_reg  <= 1'b1;
                        fpw_reg  <= 1'b1;
                        take_reg <= 1'b1;
                        ev_reg   <= 1'b1;
                    end else if (fr_found_reg) begin
                        tgt_reg  <= fr_idx_reg;
                        all_reg  <= 1'b1;
                        ins_reg  <= 1'b1;
                        act_reg  <= 1'b1;
                        fpw_reg  <= 1'b1;
                        inc_reg  <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (rv_fp_reg) begin
            old_fp_reg <= fp_rd;
        end
    end

    assign st.act = act_reg;

    // Occupancy and capacity.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
            cap_reg <= lrufp_pkg::CAP_RESET;
        end else begin
            if (cmd.fin && inc_reg) occ_reg <= occ_reg + CNT_W'(1);
            if (cfg_we) cap_reg <= cfg_wdata;
        end
    end

    // Result register; a finished result waits here until its transfer.
    always_comb begin
        out_fp_next = '0;
        if (take_reg) out_fp_next[FP_W-1:0] = old_fp_reg;
    end

    assign st.out_free = !m_tvalid_reg || m_tready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.fin) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.fin) begin
            out_hit_reg <= hit_reg;
            out_ev_reg  <= ev_reg;
            out_fp_reg  <= out_fp_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_fp_reg;
    assign m_tuser  = {out_ev_reg, out_hit_reg};

endmodule

[rtl/lru_lba_fingerprint_map.sv]
// Top level of the block address to fingerprint map.
// Depends on lrufp_pkg, lrufp_ctrl, lrufp_datapath and lrufp_ram.
//
// A least-recently-used map from a 48-bit block address to a fingerprint of
// FP_BYTES bytes, with ENTRIES slots. Commands arrive in s_tuser (lookup,
// promote, update); one result comes back for every input transfer. Entries
// live in a RAM that is walked one entry per cycle: each item first scans all
// ENTRIES slots for the key, the free slot and the oldest entry, then reads
// the fingerprint RAM, and for a promote or update that changes the order it
// walks the table a second time to rewrite the age ranks. Each item is finished
// before the next one is accepted. After reset, a clearing pass empties the
// table before the first item is taken; capacity writes are taken at any time.
module lru_lba_fingerprint_map #(
    parameter int ENTRIES  = lrufp_pkg::ENTRIES_DEF,
    parameter int FP_BYTES = lrufp_pkg::FP_BYTES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // lba [47:0], fp_low [111:48], fp_mid [175:112], fp_high [207:176]
    input  logic [207:0]  s_tdata,
    // command [1:0]
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // out_fp_low [63:0], out_fp_mid [127:64], out_fp_high [159:128]
    output logic [159:0]  m_tdata,
    // hit [0], evicted [1]
    output logic [1:0]    m_tuser,
    input  logic          cfg_we,
    input  logic [8:0]    cfg_wdata
);

    lrufp_pkg::ctrl_cmd_t  cmd;
    lrufp_pkg::dp_status_t st;

    lrufp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lrufp_datapath #(.ENTRIES(ENTRIES), .FP_BYTES(FP_BYTES)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .in_cmd    (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // One item at a time: no second transfer right after an accepted one.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    // No input is taken while the clearing pass runs.
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_wr |-> !s_tready)
        else $error("input ready during clearing pass");

    // A result is only loaded when the output register is free.
    a_fin_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |-> st.out_free)
        else $error("result loaded over a pending one");

    // A new result appears only after the controller finished an item.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.fin))
        else $error("result without finished item");

endmodule
